// ===== hw/rtl/bbd_pkg.sv =====
package bbd_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4096;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int WID_W = COL_W + 1;
  localparam int HGT_W = ROW_W + 1;

  localparam int PIX_W = 8;

  localparam int FW_FIELD_W = 12;
  localparam int FH_FIELD_W = 13;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  localparam logic [WID_W-1:0] RESET_WIDTH  = WID_W'(640);
  localparam logic [HGT_W-1:0] RESET_HEIGHT = HGT_W'(480);

  typedef logic [8:0][PIX_W-1:0] win_t;

  typedef struct packed {
    logic             valid;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    win_t             win;
  } gen_load_t;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic [COL_W-1:0] pixel_col;
    logic [ROW_W-1:0] pixel_row;
    logic             last_of_run;
    logic             end_of_frame;
  } pixel_t;

endpackage

// ===== hw/rtl/bbd_if.sv =====
interface bbd_in_if;
  import bbd_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] raw_sample;

  modport source (output valid, output raw_sample, input ready);
  modport sink (input valid, input raw_sample, output ready);
endinterface

interface bbd_out_if;
  import bbd_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] red;
  logic [PIX_W-1:0] green;
  logic [PIX_W-1:0] blue;
  logic [COL_W-1:0] pixel_col;
  logic [ROW_W-1:0] pixel_row;
  logic             last_of_run;
  logic             end_of_frame;

  modport source (output valid, output red, output green, output blue, output pixel_col,
                  output pixel_row, output last_of_run, output end_of_frame, input ready);
  modport sink (input valid, input red, input green, input blue, input pixel_col,
                input pixel_row, input last_of_run, input end_of_frame, output ready);
endinterface

// ===== hw/rtl/bbd_ram.sv =====
module bbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/bbd_out_queue.sv =====
module bbd_out_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  bbd_pkg::pixel_t push_pix,
  output logic            full,
  bbd_out_if.source       out_ch
);
  import bbd_pkg::*;

  pixel_t     ent_r [2];
  pixel_t     ent_nxt [2];
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  logic       pop;

  assign pop  = out_ch.valid && out_ch.ready;
  assign full = cnt_r[1];

  always_comb begin
    ent_nxt = ent_r;
    cnt_nxt = cnt_r;
    if (push && pop) begin
      if (cnt_r == 2'd1) begin
        ent_nxt[0] = push_pix;
      end else begin
        ent_nxt[0] = ent_r[1];
        ent_nxt[1] = push_pix;
      end
    end else if (push) begin
      ent_nxt[cnt_r[0]] = push_pix;
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop) begin
      ent_nxt[0] = ent_r[1];
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  assign out_ch.valid        = (cnt_r != 2'd0);
  assign out_ch.red          = ent_r[0].red;
  assign out_ch.green        = ent_r[0].green;
  assign out_ch.blue         = ent_r[0].blue;
  assign out_ch.pixel_col    = ent_r[0].pixel_col;
  assign out_ch.pixel_row    = ent_r[0].pixel_row;
  assign out_ch.last_of_run  = ent_r[0].last_of_run;
  assign out_ch.end_of_frame = ent_r[0].end_of_frame;

endmodule

// ===== hw/rtl/bbd_pixel_gen.sv =====
module bbd_pixel_gen (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [bbd_pkg::WID_W-1:0] frame_w,
  input  logic [bbd_pkg::HGT_W-1:0] frame_h,
  input  bbd_pkg::gen_load_t        load,
  output logic                      free,
  input  logic                      queue_full,
  output logic                      push,
  output bbd_pkg::pixel_t           push_pix
);
  import bbd_pkg::*;

  logic             v_r;
  logic [COL_W-1:0] c_r;
  logic [ROW_W-1:0] r_r;
  win_t             win_r;
  logic             ox_r;
  logic             oy_r;

  logic             last_col;
  logic             last_row;
  logic             has_next;
  logic             done;
  logic [COL_W-1:0] px;
  logic [ROW_W-1:0] py;
  logic             dx;
  logic             dy;
  logic signed [3:0] rx;
  logic signed [3:0] ry;
  logic             edge_blk;
  logic [9:0]       sum_r;
  logic [9:0]       sum_g;
  logic [9:0]       sum_b;

  function automatic logic [PIX_W-1:0] smp(input win_t w9, input logic signed [3:0] a,
                                           input logic signed [3:0] b);
    logic [3:0] idx;
    idx = {2'b00, b[1:0]} * 4'd3 + {2'b00, a[1:0]};
    if (a[3] || b[3] || (a > 4'sd2) || (b > 4'sd2)) begin
      return '0;
    end
    return w9[idx];
  endfunction

  function automatic logic [9:0] ext(input logic [PIX_W-1:0] v);
    return {2'b00, v};
  endfunction

  assign last_col = ({1'b0, c_r} == frame_w - WID_W'(1));
  assign last_row = ({1'b0, r_r} == frame_h - HGT_W'(1));
  assign has_next = (!ox_r && last_col) || (!oy_r && last_row);
  assign done     = v_r && !queue_full && !has_next;
  assign free     = !v_r || done;
  assign push     = v_r && !queue_full;

  assign px = c_r - COL_W'(1) + {{(COL_W-1){1'b0}}, ox_r};
  assign py = r_r - ROW_W'(1) + {{(ROW_W-1){1'b0}}, oy_r};
  assign dx = px[0];
  assign dy = py[0];
  assign rx = 4'sd1 + $signed({3'b000, ox_r}) - $signed({3'b000, dx});
  assign ry = 4'sd1 + $signed({3'b000, oy_r}) - $signed({3'b000, dy});

  assign edge_blk = (px[COL_W-1:1] == '0) || (py[ROW_W-1:1] == '0) ||
                    ({1'b0, px[COL_W-1:1], 1'b0} == frame_w - WID_W'(2)) ||
                    ({1'b0, py[ROW_W-1:1], 1'b0} == frame_h - HGT_W'(2));

  always_comb begin
    sum_r = '0;
    sum_g = '0;
    sum_b = '0;
    push_pix = '0;
    if (edge_blk) begin
      if (dx == dy) begin
        sum_g = ext(smp(win_r, 4'sd1 + $signed({3'b000, ox_r}),
                        4'sd1 + $signed({3'b000, oy_r})));
      end else begin
        sum_g = (ext(smp(win_r, rx, ry)) + ext(smp(win_r, rx + 4'sd1, ry + 4'sd1))) >> 1;
      end
      sum_r = ext(smp(win_r, rx, ry + 4'sd1));
      sum_b = ext(smp(win_r, rx + 4'sd1, ry));
    end else if (!dx && !dy) begin
      sum_r = (ext(smp(win_r, rx, ry + 4'sd1)) + ext(smp(win_r, rx, ry - 4'sd1))) >> 1;
      sum_g = ext(smp(win_r, rx, ry));
      sum_b = (ext(smp(win_r, rx - 4'sd1, ry)) + ext(smp(win_r, rx + 4'sd1, ry))) >> 1;
    end else if (!dx && dy) begin
      sum_r = ext(smp(win_r, rx, ry + 4'sd1));
      sum_g = (ext(smp(win_r, rx, ry)) + ext(smp(win_r, rx, ry + 4'sd2)) +
               ext(smp(win_r, rx - 4'sd1, ry + 4'sd1)) +
               ext(smp(win_r, rx + 4'sd1, ry + 4'sd1))) >> 2;
      sum_b = (ext(smp(win_r, rx + 4'sd1, ry)) + ext(smp(win_r, rx - 4'sd1, ry)) +
               ext(smp(win_r, rx + 4'sd1, ry + 4'sd2)) +
               ext(smp(win_r, rx - 4'sd1, ry + 4'sd2))) >> 2;
    end else if (dx && !dy) begin
      sum_r = (ext(smp(win_r, rx, ry + 4'sd1)) + ext(smp(win_r, rx + 4'sd2, ry + 4'sd1)) +
               ext(smp(win_r, rx, ry - 4'sd1)) +
               ext(smp(win_r, rx + 4'sd2, ry - 4'sd1))) >> 2;
      sum_g = (ext(smp(win_r, rx, ry)) + ext(smp(win_r, rx + 4'sd2, ry)) +
               ext(smp(win_r, rx + 4'sd1, ry - 4'sd1)) +
               ext(smp(win_r, rx + 4'sd1, ry + 4'sd1))) >> 2;
      sum_b = ext(smp(win_r, rx + 4'sd1, ry));
    end else begin
      sum_r = (ext(smp(win_r, rx, ry + 4'sd1)) + ext(smp(win_r, rx + 4'sd2, ry + 4'sd1))) >> 1;
      sum_g = ext(smp(win_r, rx + 4'sd1, ry + 4'sd1));
      sum_b = (ext(smp(win_r, rx + 4'sd1, ry)) + ext(smp(win_r, rx + 4'sd1, ry + 4'sd2))) >> 1;
    end
    push_pix.red          = sum_r[PIX_W-1:0];
    push_pix.green        = sum_g[PIX_W-1:0];
    push_pix.blue         = sum_b[PIX_W-1:0];
    push_pix.pixel_col    = px;
    push_pix.pixel_row    = py;
    push_pix.last_of_run  = !has_next;
    push_pix.end_of_frame = ({1'b0, px} == frame_w - WID_W'(1)) &&
                            ({1'b0, py} == frame_h - HGT_W'(1));
  end

  always_ff @(posedge clk) begin
    if (load.valid) begin
      c_r   <= load.col;
      r_r   <= load.row;
      win_r <= load.win;
    end
    if (!rst_n) begin
      v_r  <= 1'b0;
      ox_r <= 1'b0;
      oy_r <= 1'b0;
    end else if (load.valid) begin
      v_r  <= 1'b1;
      ox_r <= 1'b0;
      oy_r <= 1'b0;
    end else if (push) begin
      if (!ox_r && last_col) begin
        ox_r <= 1'b1;
      end else if (!oy_r && last_row) begin
        ox_r <= 1'b0;
        oy_r <= 1'b1;
      end else begin
        v_r <= 1'b0;
      end
    end
  end

endmodule

// ===== hw/rtl/bayer_bilinear_demosaic_core.sv =====
// Channel   Port     Dir  Payload
// -------   ------   ---  ------------------------------------------------------
// sample    in_ch    in   raw_sample
// pixel     out_ch   out  red, green, blue, pixel_col, pixel_row, last_of_run,
//                         end_of_frame
// config    cfg_*    in   cfg_index selects frame_width or frame_height
//
// One sample is taken per clock in interior rows unless the output stalls; a
// taken sample is registered with the line-store reads, then loaded into the
// pixel generator, which pushes its pixels into the output queue. The last
// sample of a row releases two pixels and each later sample of the last row
// two (four for the final one); the single pixel generator emits one a cycle
// while the queue is not full and holds the input until it has finished. Reset
// is synchronous and active low; the line stores need no clearing. A stalled
// output fills a two-item queue, then holds the generator and the sample input.
module bayer_bilinear_demosaic_core (
  input  logic                           clk,
  input  logic                           rst_n,
  bbd_in_if.sink                         in_ch,
  bbd_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [bbd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bbd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import bbd_pkg::*;

  logic [WID_W-1:0] frame_w_r;
  logic [HGT_W-1:0] frame_h_r;
  logic [COL_W-1:0] col_r;
  logic [COL_W-1:0] col_nxt;
  logic [ROW_W-1:0] row_r;
  logic [ROW_W-1:0] row_nxt;

  logic             v1_r;
  logic [COL_W-1:0] c1_r;
  logic [ROW_W-1:0] r1_r;
  logic [PIX_W-1:0] s1_r;
  win_t             win_r;
  win_t             win_nxt;

  logic [PIX_W-1:0] up_data;
  logic [PIX_W-1:0] lo_data;
  logic             accept;
  logic             emits;
  logic             retire;
  logic             gen_free;
  logic             queue_full;
  logic             push;
  pixel_t           push_pix;
  gen_load_t        load;

  function automatic logic [WID_W-1:0] eff_width(input logic [FW_FIELD_W-1:0] v);
    int unsigned t;
    t = int'(v) & ~1;
    if (t < 4) t = 4;
    if (t > (MAX_WIDTH & ~1)) t = MAX_WIDTH & ~1;
    return WID_W'(t);
  endfunction

  function automatic logic [HGT_W-1:0] eff_height(input logic [FH_FIELD_W-1:0] v);
    int unsigned t;
    t = int'(v) & ~1;
    if (t < 4) t = 4;
    if (t > (MAX_HEIGHT & ~1)) t = MAX_HEIGHT & ~1;
    return HGT_W'(t);
  endfunction

  assign accept       = in_ch.valid && in_ch.ready;
  assign emits        = (c1_r != '0) && (r1_r != '0);
  assign retire       = v1_r && (!emits || gen_free);
  assign in_ch.ready  = !v1_r || retire;

  always_comb begin
    col_nxt = col_r + COL_W'(1);
    row_nxt = row_r;
    if ({1'b0, col_r} == frame_w_r - WID_W'(1)) begin
      col_nxt = '0;
      row_nxt = row_r + ROW_W'(1);
      if ({1'b0, row_r} == frame_h_r - HGT_W'(1)) begin
        row_nxt = '0;
      end
    end
  end

  always_comb begin
    win_nxt = win_r;
    for (int k = 0; k < 3; k++) begin
      win_nxt[k*3+0] = win_r[k*3+1];
      win_nxt[k*3+1] = win_r[k*3+2];
    end
    win_nxt[2] = up_data;
    win_nxt[5] = lo_data;
    win_nxt[8] = s1_r;
  end

  always_comb begin
    load.valid = retire && emits;
    load.col   = c1_r;
    load.row   = r1_r;
    load.win   = win_nxt;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      c1_r <= col_r;
      r1_r <= row_r;
      s1_r <= in_ch.raw_sample;
    end
    if (retire) begin
      win_r <= win_nxt;
    end
    if (!rst_n) begin
      frame_w_r <= RESET_WIDTH;
      frame_h_r <= RESET_HEIGHT;
      col_r     <= '0;
      row_r     <= '0;
      v1_r      <= 1'b0;
    end else begin
      if (accept) begin
        v1_r <= 1'b1;
      end else if (retire) begin
        v1_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_FRAME_WIDTH: begin
            frame_w_r <= eff_width(cfg_wdata[FW_FIELD_W-1:0]);
          end
          REG_FRAME_HEIGHT: begin
            frame_h_r <= eff_height(cfg_wdata[FH_FIELD_W-1:0]);
          end
          default: begin
          end
        endcase
        col_r <= '0;
        row_r <= '0;
      end else if (accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
    end
  end

  bbd_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_upper (
    .clk   (clk),
    .we    (retire),
    .waddr (c1_r),
    .wdata (lo_data),
    .re    (accept),
    .raddr (col_r),
    .rdata (up_data)
  );

  bbd_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_lower (
    .clk   (clk),
    .we    (retire),
    .waddr (c1_r),
    .wdata (s1_r),
    .re    (accept),
    .raddr (col_r),
    .rdata (lo_data)
  );

  bbd_pixel_gen u_gen (
    .clk        (clk),
    .rst_n      (rst_n),
    .frame_w    (frame_w_r),
    .frame_h    (frame_h_r),
    .load       (load),
    .free       (gen_free),
    .queue_full (queue_full),
    .push       (push),
    .push_pix   (push_pix)
  );

  bbd_out_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_pix (push_pix),
    .full     (queue_full),
    .out_ch   (out_ch)
  );

endmodule
